### design/lpfs_pkg.sv
// ----------------------------------------------------------------------------
// lpfs_pkg
// Shared types and constants for the LED panel framebuffer and scan block.
// ----------------------------------------------------------------------------
package lpfs_pkg;

	// One panel holds 32 x 16 pixels, one bit each
	localparam int PANEL_BYTES = 64;

	// Field widths
	localparam int ACTION_W   = 2;
	localparam int X_W        = 7;
	localparam int Y_W        = 6;
	localparam int MODE_W     = 3;
	localparam int WORD_W     = 32;
	localparam int GROUP_W    = 2;
	localparam int CFG_DATA_W = 3;
	localparam int CFG_IDX_W  = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PANELS_WIDE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PANELS_HIGH = 1'd1;

	// Fill values
	localparam logic [7:0] BYTE_DARK = 8'hFF;
	localparam logic [7:0] BYTE_LIT  = 8'h00;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PIXEL = 2'd0,
		ACT_SCAN  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_NORMAL  = 3'd0,
		MODE_INVERSE = 3'd1,
		MODE_TOGGLE  = 3'd2,
		MODE_OR      = 3'd3,
		MODE_NOR     = 3'd4
	} draw_mode_t;

	// Pixel target within a byte, plus area check
	typedef struct packed {
		logic       in_area;
		logic [7:0] mask;
	} pix_sel_t;

endpackage

### design/lpfs_cmd_if.sv
// ----------------------------------------------------------------------------
// lpfs_cmd_if
// Command channel: pixel write, row group scan or clear.
// ----------------------------------------------------------------------------
interface lpfs_cmd_if import lpfs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [X_W-1:0]      x_pos;
	logic [Y_W-1:0]      y_pos;
	logic [MODE_W-1:0]   draw_mode;
	logic                pixel_on;
	logic                clear_normal;
	logic                other_master_active;

	modport source (
		output valid, action, x_pos, y_pos, draw_mode, pixel_on, clear_normal,
			other_master_active,
		input  ready
	);
	modport sink (
		input  valid, action, x_pos, y_pos, draw_mode, pixel_on, clear_normal,
			other_master_active,
		output ready
	);
endinterface

### design/lpfs_scan_if.sv
// ----------------------------------------------------------------------------
// lpfs_scan_if
// Scan word channel toward the panel shifter.
// ----------------------------------------------------------------------------
interface lpfs_scan_if import lpfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WORD_W-1:0]  scan_word;
	logic [GROUP_W-1:0] row_group;
	logic               last_word;

	modport source (
		output valid, scan_word, row_group, last_word,
		input  ready
	);
	modport sink (
		input  valid, scan_word, row_group, last_word,
		output ready
	);
endinterface

### design/lpfs_store.sv
// ----------------------------------------------------------------------------
// lpfs_store
// Byte-wide single-port frame memory with registered read data.
// ----------------------------------------------------------------------------
module lpfs_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Write or read one byte per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### design/lpfs_pix_map.sv
// ----------------------------------------------------------------------------
// lpfs_pix_map
// Maps a pixel position to its byte address, bit mask and area check.
// ----------------------------------------------------------------------------
module lpfs_pix_map import lpfs_pkg::*; #(
	parameter int AW    = 10,
	parameter int WW    = 3,
	parameter int HW    = 3,
	parameter int TOT_W = 5
) (
	input  logic [X_W-1:0]   x_pos,
	input  logic [Y_W-1:0]   y_pos,
	input  logic [WW-1:0]    panels_wide,
	input  logic [HW-1:0]    panels_high,
	input  logic [TOT_W-1:0] panels_total,
	output logic [AW-1:0]    addr,
	output pix_sel_t         sel
);

	logic [AW-1:0] panel;
	logic [AW-1:0] row_off;

	// Check the area, then panel index, then row offset within the store
	always_comb begin
		sel.in_area = (10'(x_pos) < 10'({panels_wide, 5'b0})) &&
			(10'(y_pos) < 10'({panels_high, 4'b0}));
		sel.mask    = 8'h80 >> x_pos[2:0];
		panel       = AW'(x_pos[6:5]) + AW'(panels_wide) * AW'(y_pos[5:4]);
		row_off     = {(AW-2)'(AW'(y_pos[3:0]) * AW'(panels_total)), 2'b00};
		addr        = row_off + AW'({panel, 2'b00}) + AW'(x_pos[4:3]);
	end

endmodule

### design/led_panel_framebuffer_scan.sv
// ----------------------------------------------------------------------------
// led_panel_framebuffer_scan
// Framebuffer for tiled one-colour LED panels at quarter scan: pixel writes
// with draw modes, clear, and row group scan out as 32-bit shift words.
//
//   channel | dir | handshake     | beat
//   cmd     | in  | valid/ready   | action, x_pos, y_pos, draw_mode, pixel_on,
//           |     |               | clear_normal, other_master_active
//   scan    | out | valid/ready   | scan_word, row_group, last_word
//   cfg     | in  | cfg_wr_en     | cfg_index, cfg_data
//
// One command is worked at a time; T = panels_wide * panels_high.
// Pixel write: accept, read, write back, on the single memory port.
// Clear: 64*T bytes, one byte written per cycle.
// Scan: 4*T words; the four byte reads per word on the one memory port set
// the rate. A stalled scan sink holds the word sequencer.
// After reset all MAX_PANELS_WIDE*MAX_PANELS_HIGH*64 bytes of the store are
// swept to 0xFF; no command is taken during the sweep.
// ----------------------------------------------------------------------------
module led_panel_framebuffer_scan import lpfs_pkg::*; #(
	parameter int MAX_PANELS_WIDE = 4,
	parameter int MAX_PANELS_HIGH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lpfs_cmd_if.sink              cmd,
	lpfs_scan_if.source           scan,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_PANELS_WIDE * MAX_PANELS_HIGH * PANEL_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_PANELS_WIDE + 1);
	localparam int HW    = $clog2(MAX_PANELS_HIGH + 1);
	localparam int TOT_W = $clog2(MAX_PANELS_WIDE * MAX_PANELS_HIGH + 1);
	localparam int IW    = TOT_W + 2;

	typedef enum logic [2:0] {
		S_FILL,
		S_IDLE,
		S_PIX_RD,
		S_PIX_WR,
		S_SCAN_RD,
		S_SCAN_PUSH
	} state_t;

	state_t            state_q;
	logic [WW-1:0]     wide_q;
	logic [HW-1:0]     high_q;
	logic [TOT_W-1:0]  total_q;
	logic [WW-1:0]     sat_wide;
	logic [HW-1:0]     sat_high;
	logic [GROUP_W-1:0] phase_q;

	logic [AW-1:0]     fill_ptr_q;
	logic [AW-1:0]     fill_end_q;
	logic [7:0]        fill_val_q;

	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	logic [MODE_W-1:0] mode_q;
	logic              on_q;
	logic [AW-1:0]     pix_addr;
	pix_sel_t          pix_sel;
	logic [AW-1:0]     pix_addr_q;
	logic [7:0]        mask_q;
	logic [7:0]        mod_byte;

	logic [AW-1:0]     a_q;
	logic [1:0]        k_q;
	logic [IW-1:0]     i_q;
	logic [IW-1:0]     last_idx;
	logic              last_q;
	logic [AW-1:0]     scan_off;
	logic [AW-1:0]     scan_addr;
	logic              rd_vld_s1;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] word_out;
	logic              push_fire;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic [GROUP_W-1:0] out_group_q;
	logic              out_last_q;

	logic              mem_en;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [7:0]        mem_wdata;
	logic [7:0]        mem_rdata;
	logic              cmd_fire;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	// Saturate configuration values to 1..max
	always_comb begin
		if (cfg_data == '0) begin
			sat_wide = WW'(1);
		end else if (int'(cfg_data) > MAX_PANELS_WIDE) begin
			sat_wide = WW'(MAX_PANELS_WIDE);
		end else begin
			sat_wide = WW'(cfg_data);
		end
		if (cfg_data == '0) begin
			sat_high = HW'(1);
		end else if (int'(cfg_data) > MAX_PANELS_HIGH) begin
			sat_high = HW'(MAX_PANELS_HIGH);
		end else begin
			sat_high = HW'(cfg_data);
		end
	end

	// Hold panel counts and their product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q  <= WW'(1);
			high_q  <= HW'(1);
			total_q <= TOT_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PANELS_WIDE: begin
					wide_q  <= sat_wide;
					total_q <= TOT_W'(sat_wide) * TOT_W'(high_q);
				end
				REG_PANELS_HIGH: begin
					high_q  <= sat_high;
					total_q <= TOT_W'(wide_q) * TOT_W'(sat_high);
				end
				default: begin
				end
			endcase
		end
	end

	lpfs_pix_map #(
		.AW    (AW),
		.WW    (WW),
		.HW    (HW),
		.TOT_W (TOT_W)
	) u_pix_map (
		.x_pos        (x_q),
		.y_pos        (y_q),
		.panels_wide  (wide_q),
		.panels_high  (high_q),
		.panels_total (total_q),
		.addr         (pix_addr),
		.sel          (pix_sel)
	);

	// Apply the draw mode to the fetched byte
	always_comb begin
		case (draw_mode_t'(mode_q))
			MODE_NORMAL:  mod_byte = on_q ? (mem_rdata & ~mask_q) : (mem_rdata | mask_q);
			MODE_INVERSE: mod_byte = on_q ? (mem_rdata | mask_q) : (mem_rdata & ~mask_q);
			MODE_TOGGLE:  mod_byte = on_q ? (mem_rdata ^ mask_q) : mem_rdata;
			MODE_OR:      mod_byte = on_q ? (mem_rdata & ~mask_q) : mem_rdata;
			MODE_NOR:     mod_byte = (on_q && ((mem_rdata & mask_q) == 8'h00)) ?
				(mem_rdata | mask_q) : mem_rdata;
			default:      mod_byte = mem_rdata;
		endcase
	end

	// Scan address: word base plus the plane offset, top byte read first
	always_comb begin
		case (k_q)
			2'd0:    scan_off = AW'({total_q, 5'b0}) + AW'({total_q, 4'b0});
			2'd1:    scan_off = AW'({total_q, 5'b0});
			2'd2:    scan_off = AW'({total_q, 4'b0});
			default: scan_off = '0;
		endcase
		scan_addr = a_q + scan_off;
		last_idx  = IW'({total_q, 2'b00}) - IW'(1);
		word_out  = rd_vld_s1 ? {word_q[WORD_W-9:0], mem_rdata} : word_q;
		push_fire = (state_q == S_SCAN_PUSH) && (!out_valid_q || scan.ready);
	end

	// Drive the single memory port
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = scan_addr;
		mem_wdata = mod_byte;
		case (state_q)
			S_FILL: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = fill_ptr_q;
				mem_wdata = fill_val_q;
			end
			S_PIX_RD: begin
				mem_en   = pix_sel.in_area;
				mem_addr = pix_addr;
			end
			S_PIX_WR: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = pix_addr_q;
			end
			S_SCAN_RD: begin
				mem_en = 1'b1;
			end
			S_SCAN_PUSH: begin
				mem_en = push_fire && !last_q;
			end
			default: begin
			end
		endcase
	end

	lpfs_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Sequencer: state, counters and scan phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_FILL;
			fill_ptr_q <= '0;
			fill_end_q <= AW'(DEPTH - 1);
			fill_val_q <= BYTE_DARK;
			phase_q    <= '0;
			a_q        <= '0;
			k_q        <= '0;
			i_q        <= '0;
			last_q     <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_en && !mem_we &&
				(state_q == S_SCAN_RD || state_q == S_SCAN_PUSH);
			case (state_q)
				S_FILL: begin
					if (fill_ptr_q == fill_end_q) begin
						state_q <= S_IDLE;
					end else begin
						fill_ptr_q <= fill_ptr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (cmd_fire) begin
						case (action_t'(cmd.action))
							ACT_PIXEL: begin
								state_q <= S_PIX_RD;
							end
							ACT_SCAN: begin
								if (!cmd.other_master_active) begin
									a_q     <= {(AW-2)'(AW'(total_q) * AW'(phase_q)), 2'b00};
									k_q     <= '0;
									i_q     <= '0;
									state_q <= S_SCAN_RD;
								end
							end
							ACT_CLEAR: begin
								fill_ptr_q <= '0;
								fill_end_q <= AW'({total_q, 6'b0} - 1);
								fill_val_q <= cmd.clear_normal ? BYTE_DARK : BYTE_LIT;
								state_q    <= S_FILL;
							end
							default: begin
							end
						endcase
					end
				end
				S_PIX_RD: begin
					state_q <= pix_sel.in_area ? S_PIX_WR : S_IDLE;
				end
				S_PIX_WR: begin
					state_q <= S_IDLE;
				end
				S_SCAN_RD: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						a_q     <= a_q + AW'(1);
						i_q     <= i_q + IW'(1);
						last_q  <= (i_q == last_idx);
						state_q <= S_SCAN_PUSH;
					end
				end
				S_SCAN_PUSH: begin
					if (push_fire) begin
						if (last_q) begin
							phase_q <= phase_q + 2'd1;
							state_q <= S_IDLE;
						end else begin
							k_q     <= 2'd1;
							state_q <= S_SCAN_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Latch the pixel command and the write target; shift fetched scan bytes into the word
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			x_q    <= cmd.x_pos;
			y_q    <= cmd.y_pos;
			mode_q <= cmd.draw_mode;
			on_q   <= cmd.pixel_on;
		end
		if (state_q == S_PIX_RD) begin
			pix_addr_q <= pix_addr;
			mask_q     <= pix_sel.mask;
		end
		if (rd_vld_s1) begin
			word_q <= {word_q[WORD_W-9:0], mem_rdata};
		end
	end

	// Output register: load on push, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_fire) begin
			out_valid_q <= 1'b1;
		end else if (scan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			out_word_q  <= word_out;
			out_group_q <= phase_q;
			out_last_q  <= last_q;
		end
	end

	assign scan.valid     = out_valid_q;
	assign scan.scan_word = out_word_q;
	assign scan.row_group = out_group_q;
	assign scan.last_word = out_last_q;

	// Finishing a scan advances the row group by one
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && last_q) |=> (phase_q == $past(phase_q) + 2'd1))
		else $error("row group did not advance after last word");

	// Scan states only read the store
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_RD || state_q == S_SCAN_PUSH) |-> !mem_we)
		else $error("store written during scan");

	// Fill sweep stays inside its range
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (fill_ptr_q <= fill_end_q))
		else $error("fill pointer beyond end");

	// A new output beat comes only from the push state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_SCAN_PUSH))
		else $error("output beat without push");

	// The last byte of a word arrives on entry to push
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_PUSH && $past(state_q == S_SCAN_RD)) |-> rd_vld_s1)
		else $error("word incomplete at push");

endmodule

### tb/led_panel_framebuffer_scan_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_panel_framebuffer_scan_test
// Self-checking bench for the LED panel framebuffer. A shadow copy of the
// frame store, row group and panel counts predicts every scan word. The run
// opens with a short list of directed commands, then sweeps several panel
// layouts with random traffic. Both channels idle at random, and one phase
// backs up the scan output long enough to stall the command input.
// ----------------------------------------------------------------------------
module led_panel_framebuffer_scan_test;
	import lpfs_pkg::*;

	localparam int PANELS_W_MAX   = 4;
	localparam int PANELS_H_MAX   = 4;
	localparam int STORE_SIZE     = PANELS_W_MAX * PANELS_H_MAX * PANEL_BYTES;
	// Longest silent command is a full clear, one byte per cycle
	localparam int SETTLE_CYCLES  = STORE_SIZE + 200;
	localparam int HOLD_CYCLES    = 400;
	localparam int IDLE_PCT       = 11;
	localparam int RAND_PER_PHASE = 54;
	localparam int NUM_PHASES     = 8;
	localparam int CALM_PHASE     = 2;
	localparam int SQUEEZE_PHASE  = 3;
	localparam int DRAIN_LIMIT    = 200000;
	localparam int PRINT_LIMIT    = 40;

	// Codes outside the package enums, used to hit the ignore paths
	localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;
	localparam logic [MODE_W-1:0]   MODE_BAD_LO = 3'd5;
	localparam logic [MODE_W-1:0]   MODE_BAD_HI = 3'd7;

	// Panel layouts per phase; zero and values above the maximum saturate
	localparam logic [CFG_DATA_W-1:0] PHASE_WIDE [NUM_PHASES] =
		'{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd1, 3'd5};
	localparam logic [CFG_DATA_W-1:0] PHASE_HIGH [NUM_PHASES] =
		'{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd1, 3'd4, 3'd2};

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [X_W-1:0]      x_pos;
		logic [Y_W-1:0]      y_pos;
		logic [MODE_W-1:0]   draw_mode;
		logic                pixel_on;
		logic                clear_normal;
		logic                other_master_active;
	} cmd_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0]  scan_word;
		logic [GROUP_W-1:0] row_group;
		logic               last_word;
	} scan_beat_t;

	typedef struct packed {
		cmd_beat_t         cmd;
		logic              pinned;
		logic [WORD_W-1:0] pin_word;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lpfs_cmd_if  cmd_ch ();
	lpfs_scan_if scan_ch ();

	// Shadow of the block state
	logic [7:0]            fb_shadow [STORE_SIZE];
	logic [GROUP_W-1:0]    group_shadow;
	logic [CFG_DATA_W-1:0] wide_shadow;
	logic [CFG_DATA_W-1:0] high_shadow;

	scan_beat_t  words_due [$];
	int unsigned mismatch_cnt = 0;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;

	led_panel_framebuffer_scan #(
		.MAX_PANELS_WIDE(PANELS_W_MAX),
		.MAX_PANELS_HIGH(PANELS_H_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.scan      (scan_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(string what);
		if (mismatch_cnt < PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		mismatch_cnt++;
	endtask

	function automatic int unsigned eff_panels(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return 32'(v);
	endfunction

	// Read-modify-write of one pixel in the shadow store
	function automatic void shadow_pixel(cmd_beat_t c);
		int unsigned w, h, t, panel, col, addr;
		logic [7:0]  mask, b;
		w = eff_panels(wide_shadow, PANELS_W_MAX);
		h = eff_panels(high_shadow, PANELS_H_MAX);
		t = w * h;
		if (c.x_pos >= 32 * w || c.y_pos >= 16 * h) return;
		panel = c.x_pos / 32 + w * (c.y_pos / 16);
		col   = c.x_pos % 32 + panel * 32;
		addr  = col / 8 + (c.y_pos % 16) * t * 4;
		mask  = 8'h80 >> col[2:0];
		b     = fb_shadow[addr];
		// Lit clears the bit, dark sets it
		case (c.draw_mode)
			MODE_NORMAL:  b = c.pixel_on ? (b & ~mask) : (b | mask);
			MODE_INVERSE: b = c.pixel_on ? (b | mask) : (b & ~mask);
			MODE_TOGGLE:  if (c.pixel_on) b = b ^ mask;
			MODE_OR:      if (c.pixel_on) b = b & ~mask;
			MODE_NOR:     if (c.pixel_on && (b & mask) == 8'h00) b = b | mask;
			default:      ;
		endcase
		fb_shadow[addr] = b;
	endfunction

	// Apply one accepted command to the shadow; queue the scan words it causes
	function automatic int unsigned shadow_apply(cmd_beat_t c);
		int unsigned t, rowsize, base, a, i;
		scan_beat_t  sb;
		t = eff_panels(wide_shadow, PANELS_W_MAX) * eff_panels(high_shadow, PANELS_H_MAX);
		case (c.action)
			ACT_PIXEL: shadow_pixel(c);
			ACT_CLEAR: begin
				for (i = 0; i < t * PANEL_BYTES; i++) begin
					fb_shadow[i] = c.clear_normal ? BYTE_DARK : BYTE_LIT;
				end
			end
			ACT_SCAN: begin
				if (!c.other_master_active) begin
					rowsize = 4 * t;
					base    = rowsize * group_shadow;
					for (i = 0; i < rowsize; i++) begin
						a = base + i;
						sb.scan_word = {fb_shadow[a + 48 * t], fb_shadow[a + 32 * t],
							fb_shadow[a + 16 * t], fb_shadow[a]};
						sb.row_group = group_shadow;
						sb.last_word = (i == rowsize - 1);
						words_due.push_back(sb);
					end
					group_shadow = group_shadow + 1'b1;
					return rowsize;
				end
			end
			default: ;
		endcase
		return 0;
	endfunction

	// Offer one command, with a random gap before it, and wait for the beat
	task automatic offer_cmd(cmd_beat_t c, output int unsigned n_words);
		int unsigned gap;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) gap++;
		end
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid               <= 1'b1;
		cmd_ch.action              <= c.action;
		cmd_ch.x_pos               <= c.x_pos;
		cmd_ch.y_pos               <= c.y_pos;
		cmd_ch.draw_mode           <= c.draw_mode;
		cmd_ch.pixel_on            <= c.pixel_on;
		cmd_ch.clear_normal        <= c.clear_normal;
		cmd_ch.other_master_active <= c.other_master_active;
		do @(posedge clk); while (!cmd_ch.ready);
		n_words = shadow_apply(c);
	endtask

	// Write both panel counts on back-to-back edges
	task automatic write_panels(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_PANELS_WIDE;
		cfg_data  <= w;
		@(posedge clk);
		wide_shadow = w;
		cfg_index <= REG_PANELS_HIGH;
		cfg_data  <= h;
		@(posedge clk);
		high_shadow = h;
		cfg_wr_en <= 1'b0;
	endtask

	// Wait for outstanding scan words, then let any silent command finish
	task automatic settle_idle();
		int unsigned k;
		for (k = 0; k < DRAIN_LIMIT && words_due.size() != 0; k++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic stim_row_t mk_row(logic [ACTION_W-1:0] action, int unsigned x,
		int unsigned y, logic [MODE_W-1:0] mode, logic on, logic normal, logic busy,
		logic pinned, logic [WORD_W-1:0] pin_word);
		stim_row_t r;
		r.cmd.action              = action;
		r.cmd.x_pos               = x[X_W-1:0];
		r.cmd.y_pos               = y[Y_W-1:0];
		r.cmd.draw_mode           = mode;
		r.cmd.pixel_on            = on;
		r.cmd.clear_normal        = normal;
		r.cmd.other_master_active = busy;
		r.pinned                  = pinned;
		r.pin_word                = pin_word;
		return r;
	endfunction

	// Random command: mostly in-area pixel writes and scans, some noise
	function automatic cmd_beat_t gen_random_cmd(int unsigned scan_pct);
		cmd_beat_t   c;
		int unsigned r, w, h;
		w = eff_panels(wide_shadow, PANELS_W_MAX);
		h = eff_panels(high_shadow, PANELS_H_MAX);
		c.action              = ACT_PIXEL;
		c.x_pos               = X_W'($urandom_range(0, 127));
		c.y_pos               = Y_W'($urandom_range(0, 63));
		c.draw_mode           = MODE_W'($urandom_range(0, 7));
		c.pixel_on            = 1'($urandom_range(0, 1));
		c.clear_normal        = 1'($urandom_range(0, 1));
		c.other_master_active = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < scan_pct) begin
			c.action              = ACT_SCAN;
			c.other_master_active = ($urandom_range(0, 99) < 20);
		end else if (r < scan_pct + 3) begin
			c.action = ACT_CLEAR;
		end else if (r < scan_pct + 5) begin
			c.action = ACT_NONE;
		end else if (r >= scan_pct + 17) begin
			c.x_pos     = X_W'($urandom_range(0, 32 * w - 1));
			c.y_pos     = Y_W'($urandom_range(0, 16 * h - 1));
			c.draw_mode = MODE_W'($urandom_range(0, 4));
		end
		return c;
	endfunction

	// Scan sink: random back-pressure, a long hold on request, and checking
	initial begin
		int unsigned hold_left;
		scan_beat_t  want;
		hold_left     = 0;
		scan_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (scan_ch.valid && scan_ch.ready) begin
				if (words_due.size() == 0) begin
					report_mismatch($sformatf("unexpected beat word=%h group=%0d last=%0b",
						scan_ch.scan_word, scan_ch.row_group, scan_ch.last_word));
				end else begin
					want = words_due.pop_front();
					if (scan_ch.scan_word !== want.scan_word)
						report_mismatch($sformatf("scan_word %h, want %h",
							scan_ch.scan_word, want.scan_word));
					if (scan_ch.row_group !== want.row_group)
						report_mismatch($sformatf("row_group %0d, want %0d",
							scan_ch.row_group, want.row_group));
					if (scan_ch.last_word !== want.last_word)
						report_mismatch($sformatf("last_word %0b, want %0b",
							scan_ch.last_word, want.last_word));
				end
			end
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (!arst_n) begin
				scan_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				scan_ch.ready <= 1'b0;
			end else begin
				scan_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Stimulus
	initial begin
		stim_row_t   rows [$];
		cmd_beat_t   c;
		int unsigned n, k, ph, i, scan_pct;

		arst_n                     = 1'b0;
		cfg_wr_en                  = 1'b0;
		cfg_index                  = REG_PANELS_WIDE;
		cfg_data                   = '0;
		cmd_ch.valid               = 1'b0;
		cmd_ch.action              = ACT_PIXEL;
		cmd_ch.x_pos               = '0;
		cmd_ch.y_pos               = '0;
		cmd_ch.draw_mode           = MODE_NORMAL;
		cmd_ch.pixel_on            = 1'b0;
		cmd_ch.clear_normal        = 1'b0;
		cmd_ch.other_master_active = 1'b0;
		for (i = 0; i < STORE_SIZE; i++) fb_shadow[i] = BYTE_DARK;
		group_shadow = '0;
		wide_shadow  = 3'd1;
		high_shadow  = 3'd1;

		// Directed list, one panel: reset contents, clears, every draw mode,
		// off-area writes, ignored codes and a busy bus
		rows.push_back(mk_row(ACT_SCAN,  0,  0, MODE_NORMAL,  0, 0, 0, 1, 32'hFFFF_FFFF));
		rows.push_back(mk_row(ACT_SCAN,  0,  0, MODE_NORMAL,  0, 0, 1, 0, '0));
		rows.push_back(mk_row(ACT_CLEAR, 0,  0, MODE_NORMAL,  0, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_SCAN,  0,  0, MODE_NORMAL,  0, 0, 0, 1, 32'h0000_0000));
		rows.push_back(mk_row(ACT_CLEAR, 0,  0, MODE_NORMAL,  0, 1, 0, 0, '0));
		rows.push_back(mk_row(ACT_SCAN,  0,  0, MODE_NORMAL,  0, 0, 0, 1, 32'hFFFF_FFFF));
		rows.push_back(mk_row(ACT_PIXEL, 0,  0, MODE_NORMAL,  1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 31, 15, MODE_NORMAL, 1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 127, 63, MODE_NORMAL, 1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 32, 0, MODE_NORMAL,  1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 0,  16, MODE_NORMAL, 1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 8,  4, MODE_INVERSE, 0, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 0,  0, MODE_INVERSE, 1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 9,  4, MODE_TOGGLE,  1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 8,  4, MODE_TOGGLE,  0, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 16, 8, MODE_OR,      1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 17, 8, MODE_OR,      0, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 16, 8, MODE_NOR,     1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 1,  0, MODE_BAD_LO,  1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_PIXEL, 2,  0, MODE_BAD_HI,  1, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_NONE, 127, 63, MODE_BAD_HI, 1, 1, 1, 0, '0));
		rows.push_back(mk_row(ACT_SCAN,  0,  0, MODE_NORMAL,  0, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_SCAN,  0,  0, MODE_NORMAL,  0, 0, 0, 0, '0));
		rows.push_back(mk_row(ACT_SCAN,  0,  0, MODE_NORMAL,  0, 0, 0, 0, '0));

		// Release reset
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed list; pinned rows also cross-check the shadow
		foreach (rows[r]) begin
			offer_cmd(rows[r].cmd, n);
			if (rows[r].pinned) begin
				for (k = words_due.size() - n; k < words_due.size(); k++) begin
					if (words_due[k].scan_word !== rows[r].pin_word)
						report_mismatch($sformatf("row %0d shadow word %h, listed %h",
							r, words_due[k].scan_word, rows[r].pin_word));
				end
			end
		end

		// Random phases over a range of panel layouts
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				cmd_ch.valid <= 1'b0;
				settle_idle();
				write_panels(PHASE_WIDE[ph], PHASE_HIGH[ph]);
			end
			calm     = (ph == CALM_PHASE);
			scan_pct = 18;
			if (ph == SQUEEZE_PHASE) begin
				// Back up the scan output while commands keep coming
				hold_req = 1'b1;
				scan_pct = 40;
			end
			for (i = 0; i < RAND_PER_PHASE; i++) begin
				c = gen_random_cmd(scan_pct);
				offer_cmd(c, n);
			end
		end
		cmd_ch.valid <= 1'b0;
		calm = 1'b0;

		settle_idle();
		if (words_due.size() != 0)
			report_mismatch($sformatf("%0d scan words never arrived", words_due.size()));
		if (mismatch_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
